[rtl/mhbc_pkg.sv]
// Shared types, constants and the rotate function for the block compression core
package mhbc_pkg;

    localparam int unsigned NumWords  = 128;
    localparam int unsigned FullCount = 256;
    localparam int unsigned WordW     = 64;

    localparam logic [1:0] StatusOk    = 2'd0;
    localparam logic [1:0] StatusOver  = 2'd1;
    localparam logic [1:0] StatusEarly = 2'd2;

    localparam logic ReqLoad     = 1'b0;
    localparam logic ReqFinalize = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COPY,
        ST_PERM,
        ST_EMIT,
        ST_ERR
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic       load;
        logic       copy_en;
        logic [6:0] copy_idx;
        logic       perm_en;
        logic       col_pass;
        logic [2:0] grp;
        logic [5:0] phase;
        logic       emit_en;
        logic       emit_rd;
        logic [5:0] emit_idx;
        logic       out_load;
        logic       out_err;
        logic [1:0] err_code;
        logic       out_last;
        logic       clear_fill;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic       full;
        logic       out_busy;
        logic       pair_rdy;
        logic       rmw_busy;
    } stat_t;

    function automatic logic [63:0] rotr(input logic [63:0] v, input int unsigned n);
        rotr = (v >> n) | (v << (64 - n));
    endfunction

endpackage

[rtl/memory_hard_block_compress_core.sv]
// A load word is taken while the controller is idle; an error result passes
// through the error state to the output register. A finalize copies all 128
// words, then runs 16 permutations on one shared half-G unit and the work RAM
// port, then emits 64 pairs. Lower-half load words are taken one per cycle while
// idle; an upper-half one holds the input for its read-modify-write.
// Reset: rst_n asynchronous, active low; clears fill count and control state.
module memory_hard_block_compress_core
    import mhbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [63:0] data_word,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] word_even,
    output logic [63:0] word_odd,
    output logic        last_pair,
    output logic [1:0]  status
);

    cmd_t  cmd;
    stat_t stat;

    mhbc_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .req_type(req_type),
        .stat(stat), .in_stall(in_stall), .cmd(cmd)
    );

    mhbc_dp u_dp (
        .clk(clk), .rst_n(rst_n), .data_word(data_word), .cmd(cmd),
        .out_stall(out_stall), .stat(stat), .out_valid(out_valid),
        .word_even(word_even), .word_odd(word_odd), .last_pair(last_pair),
        .status(status)
    );

endmodule

[rtl/mhbc_ram.sv]
// Generic single-port RAM with registered read
module mhbc_ram #(
    parameter int unsigned Width = 64,
    parameter int unsigned Depth = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[rtl/mhbc_ctrl.sv]
// Controller state machine sequencing load, compression and output
module mhbc_ctrl
    import mhbc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    input  logic   req_type,
    input  stat_t  stat,
    output logic   in_stall,
    output cmd_t   cmd
);

    state_t     state_reg, state_next;
    logic [6:0] cnt_reg, cnt_next;     // copy index / emit index
    logic [3:0] grp_reg, grp_next;     // bit 3: column pass
    logic [5:0] ph_reg, ph_next;       // permutation phase
    logic       err_reg, err_next;     // 0 overfill, 1 early

    localparam logic [5:0] PhLast = 6'd49;

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        grp_next   = grp_reg;
        ph_next    = ph_reg;
        err_next   = err_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                // an upper-half load holds the input for its read-modify-write
                if (in_valid && !stat.rmw_busy)
                begin
                    if (req_type == ReqLoad)
                    begin
                        if (stat.full)
                        begin
                            state_next = ST_ERR;
                            err_next   = 1'b0;
                        end
                    end
                    else if (!stat.full)
                    begin
                        state_next = ST_ERR;
                        err_next   = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_COPY;
                        cnt_next   = '0;
                    end
                end
            end
            ST_COPY:
            begin
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd127)
                begin
                    state_next = ST_PERM;
                    grp_next   = '0;
                    ph_next    = '0;
                end
            end
            ST_PERM:
            begin
                ph_next = ph_reg + 6'd1;
                if (ph_reg == PhLast)
                begin
                    ph_next  = '0;
                    grp_next = grp_reg + 4'd1;
                    if (grp_reg == 4'd15)
                    begin
                        state_next = ST_EMIT;
                        cnt_next   = '0;
                    end
                end
            end
            ST_EMIT:
            begin
                // cnt: bit0 selects phase (even read, then odd read and output load)
                if (!(cnt_reg[0] && (stat.out_busy || !stat.pair_rdy)))
                begin
                    cnt_next = cnt_reg + 7'd1;
                    if (cnt_reg == 7'd127)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_ERR:
            begin
                if (!stat.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        cmd.copy_idx = cnt_reg;
        cmd.grp      = grp_reg[2:0];
        cmd.col_pass = grp_reg[3];
        cmd.phase    = ph_reg;
        cmd.emit_idx = cnt_reg[6:1];
        cmd.err_code = err_reg ? StatusEarly : StatusOver;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = stat.rmw_busy;
                cmd.load = in_valid && !stat.rmw_busy && (req_type == ReqLoad) &&
                           !stat.full;
            end
            ST_COPY:  cmd.copy_en = 1'b1;
            ST_PERM:  cmd.perm_en = 1'b1;
            ST_EMIT:
            begin
                cmd.emit_en    = 1'b1;
                cmd.emit_rd    = !cnt_reg[0];
                cmd.out_load   = cnt_reg[0] && stat.pair_rdy && !stat.out_busy;
                cmd.out_last   = (cnt_reg == 7'd127);
                cmd.clear_fill = (cnt_reg == 7'd127) && stat.pair_rdy && !stat.out_busy;
            end
            ST_ERR:
            begin
                cmd.out_load = !stat.out_busy;
                cmd.out_err  = 1'b1;
                cmd.out_last = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            grp_reg   <= '0;
            ph_reg    <= '0;
            err_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            grp_reg   <= grp_next;
            ph_reg    <= ph_next;
            err_reg   <= err_next;
        end
    end

endmodule

[rtl/mhbc_dp.sv]
// Datapath: R and work RAMs, 16-word permutation file, one half-G unit, output register
module mhbc_dp
    import mhbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [63:0] data_word,
    input  cmd_t        cmd,
    input  logic        out_stall,
    output stat_t       stat,
    output logic        out_valid,
    output logic [63:0] word_even,
    output logic [63:0] word_odd,
    output logic        last_pair,
    output logic [1:0]  status
);

    logic [8:0]  fill_reg;
    logic [63:0] v_reg [16];
    logic [63:0] rd_r, rd_w;
    logic        r_we, w_we;
    logic [6:0]  r_addr, w_addr;
    logic [63:0] r_wdata, w_wdata;
    logic [63:0] even_reg;
    logic        ovalid_reg;
    logic        last_reg;
    logic [1:0]  st_reg;
    logic        rmw_reg;
    logic [6:0]  rmw_addr_reg;
    logic [63:0] rmw_data_reg;
    logic [6:0]  emit_addr;
    logic [63:0] odd_even_even_reg, odd_even_odd_reg;

    // phase plan: 0 idle (lets the last copy write through), 1..16 read issue,
    // 2..17 capture, 18..33 half-G steps (8 mixes x 2), 34..49 write back
    logic [3:0]  lane;
    logic [6:0]  lane_addr;
    logic        cap_ph, mix_ph, wr_ph;
    logic [3:0]  rd_lane, cap_lane, wr_lane, mix_step;
    logic [2:0]  mix_sel;
    logic        mix_half;

    // word address of lane j in the current row or column group
    function automatic logic [6:0] addr_of(input logic col, input logic [2:0] g,
                                           input logic [3:0] j);
        if (!col)
            addr_of = {g, j};
        else
            addr_of = {j[3:1], g, j[0]};
    endfunction

    assign cap_ph   = cmd.perm_en && (cmd.phase >= 6'd2) && (cmd.phase <= 6'd17);
    assign mix_ph   = cmd.perm_en && (cmd.phase >= 6'd18) && (cmd.phase <= 6'd33);
    assign wr_ph    = cmd.perm_en && (cmd.phase >= 6'd34) && (cmd.phase <= 6'd49);
    assign rd_lane  = 4'(cmd.phase - 6'd1);
    assign cap_lane = 4'(cmd.phase - 6'd2);
    assign mix_step = 4'(cmd.phase - 6'd18);
    assign mix_sel  = mix_step[3:1];
    assign mix_half = mix_step[0];
    assign wr_lane  = 4'(cmd.phase - 6'd34);
    assign lane     = wr_ph ? wr_lane : rd_lane;
    assign lane_addr = addr_of(cmd.col_pass, cmd.grp, lane);

    // emit: even word on the read phase, odd word while waiting to load
    assign emit_addr = {cmd.emit_idx, !cmd.emit_rd};

    // R RAM port: load (write), copy and emit reads
    always_comb
    begin
        r_we    = 1'b0;
        r_addr  = cmd.copy_idx;
        r_wdata = data_word;
        if (cmd.load)
        begin
            r_addr = fill_reg[6:0];
            if (fill_reg[7])
            begin
                r_we = 1'b0;  // xor needs read first; handled by rmw below
            end
            else
            begin
                r_we = 1'b1;
            end
        end
        else if (rmw_reg)
        begin
            r_we    = 1'b1;
            r_addr  = rmw_addr_reg;
            r_wdata = rd_r ^ rmw_data_reg;
        end
        else if (cmd.emit_en)
        begin
            r_addr = emit_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rmw_reg <= 1'b0;
        end
        else
        begin
            rmw_reg <= cmd.load && fill_reg[7];
        end
    end

    always_ff @(posedge clk)
    begin
        rmw_addr_reg <= fill_reg[6:0];
        rmw_data_reg <= data_word;
    end

    mhbc_ram #(.Width(WordW), .Depth(NumWords)) u_r_ram (
        .clk(clk), .we(r_we), .addr(r_addr), .wdata(r_wdata), .rdata(rd_r)
    );

    // work RAM: copy writes (delayed by a register), perm reads/writes, emit reads
    logic       cp_v_reg;
    logic [6:0] cp_a_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cp_v_reg <= 1'b0;
        end
        else
        begin
            cp_v_reg <= cmd.copy_en;
        end
    end

    always_ff @(posedge clk)
    begin
        cp_a_reg <= cmd.copy_idx;
    end

    always_comb
    begin
        w_we    = 1'b0;
        w_addr  = lane_addr;
        w_wdata = v_reg[wr_lane];
        if (cp_v_reg)
        begin
            w_we    = 1'b1;
            w_addr  = cp_a_reg;
            w_wdata = rd_r;
        end
        else if (wr_ph)
        begin
            w_we = 1'b1;
        end
        else if (cmd.emit_en)
        begin
            w_addr = emit_addr;
        end
    end

    mhbc_ram #(.Width(WordW), .Depth(NumWords)) u_w_ram (
        .clk(clk), .we(w_we), .addr(w_addr), .wdata(w_wdata), .rdata(rd_w)
    );

    // half a G mix per cycle on the register file
    logic [3:0]  ia, ib, ic, id;
    logic [63:0] a1, b1, c1, d1;

    always_comb
    begin
        case (mix_sel)
            3'd0: begin ia = 4'd0; ib = 4'd4; ic = 4'd8;  id = 4'd12; end
            3'd1: begin ia = 4'd1; ib = 4'd5; ic = 4'd9;  id = 4'd13; end
            3'd2: begin ia = 4'd2; ib = 4'd6; ic = 4'd10; id = 4'd14; end
            3'd3: begin ia = 4'd3; ib = 4'd7; ic = 4'd11; id = 4'd15; end
            3'd4: begin ia = 4'd0; ib = 4'd5; ic = 4'd10; id = 4'd15; end
            3'd5: begin ia = 4'd1; ib = 4'd6; ic = 4'd11; id = 4'd12; end
            3'd6: begin ia = 4'd2; ib = 4'd7; ic = 4'd8;  id = 4'd13; end
            default: begin ia = 4'd3; ib = 4'd4; ic = 4'd9; id = 4'd14; end
        endcase
        // first half rotates by 32 and 24, second half by 16 and 63
        a1 = v_reg[ia] + v_reg[ib];
        d1 = rotr(v_reg[id] ^ a1, mix_half ? 16 : 32);
        c1 = v_reg[ic] + d1;
        b1 = rotr(v_reg[ib] ^ c1, mix_half ? 63 : 24);
    end

    always_ff @(posedge clk)
    begin
        if (cap_ph)
        begin
            v_reg[cap_lane] <= rd_w;
        end
        else if (mix_ph)
        begin
            v_reg[ia] <= a1;
            v_reg[ib] <= b1;
            v_reg[ic] <= c1;
            v_reg[id] <= d1;
        end
    end

    // fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (cmd.clear_fill)
        begin
            fill_reg <= '0;
        end
        else if (cmd.load)
        begin
            fill_reg <= fill_reg + 9'd1;
        end
    end

    // even word is registered in even_reg; odd word feeds the output load directly
    logic emit_odd_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_odd_reg <= 1'b0;
        end
        else
        begin
            emit_odd_reg <= cmd.emit_rd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_odd_reg)
        begin
            even_reg <= rd_w ^ rd_r;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            ovalid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            last_reg <= cmd.out_last;
            st_reg   <= cmd.out_err ? cmd.err_code : StatusOk;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            odd_even_even_reg <= cmd.out_err ? '0 : even_reg;
            odd_even_odd_reg  <= cmd.out_err ? '0 : (rd_w ^ rd_r);
        end
    end

    always_comb
    begin
        stat.full     = fill_reg[8];
        stat.out_busy = ovalid_reg && out_stall;
        stat.pair_rdy = !emit_odd_reg;
        stat.rmw_busy = rmw_reg;
    end

    assign out_valid     = ovalid_reg;
    assign word_even     = odd_even_even_reg;
    assign word_odd      = odd_even_odd_reg;
    assign last_pair     = last_reg;
    assign status        = st_reg;

endmodule

[rtl/mhbc_checker.sv]
// Port-level checks for the compression core, bound to the top level
module mhbc_checker
    import mhbc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic        last_pair,
    input logic [1:0]  status,
    input logic [63:0] word_even
);

    // a stalled word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(word_even))
        else $error("stalled output changed");

    // error words are flagged last
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != StatusOk |-> last_pair)
        else $error("error without last");

    // error words carry zero data
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != StatusOk |-> word_even == '0)
        else $error("error data not zero");

    // status code in range
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != 2'd3)
        else $error("bad status");

endmodule

bind memory_hard_block_compress_core mhbc_checker u_chk (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
    .last_pair(last_pair), .status(status), .word_even(word_even)
);

[test/tb_memory_hard_block_compress_core.sv]
// Testbench for the block compression core: queued driver, monitor and compression predictor
`timescale 1ns / 1ps

module tb_memory_hard_block_compress_core;
    import mhbc_pkg::*;

    typedef struct {
        logic        req;
        logic [63:0] word;
    } req_item_t;

    typedef struct {
        logic [63:0] even;
        logic [63:0] odd;
        logic        last;
        logic [1:0]  stat;
    } pair_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        req_type;
    logic [63:0] data_word;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] word_even;
    logic [63:0] word_odd;
    logic        last_pair;
    logic [1:0]  status;

    req_item_t   pending_q[$];
    pair_t       expected_q[$];
    int          n_errors;
    int          n_pairs_seen;
    longint      cycle_cnt;
    int          send_gap;
    int          recv_gap;
    bit          gaps_on;
    bit          in_acc;

    // predictor state
    logic [63:0] r_block[NumWords];
    int          fill;

    memory_hard_block_compress_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .data_word (data_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .word_even (word_even),
        .word_odd  (word_odd),
        .last_pair (last_pair),
        .status    (status)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [63:0] ror64(logic [63:0] v, int n);
        return (v >> n) | (v << (64 - n));
    endfunction

    // one Blake2b-style quarter mix, additions only
    task automatic g_mix(inout logic [63:0] v[16], input int a, b, c, d);
        v[a] = v[a] + v[b];
        v[d] = ror64(v[d] ^ v[a], 32);
        v[c] = v[c] + v[d];
        v[b] = ror64(v[b] ^ v[c], 24);
        v[a] = v[a] + v[b];
        v[d] = ror64(v[d] ^ v[a], 16);
        v[c] = v[c] + v[d];
        v[b] = ror64(v[b] ^ v[c], 63);
    endtask

    task automatic permute(inout logic [63:0] m[NumWords], input int idx[16]);
        logic [63:0] v[16];
        for (int i = 0; i < 16; i++) v[i] = m[idx[i]];
        g_mix(v, 0, 4, 8, 12);
        g_mix(v, 1, 5, 9, 13);
        g_mix(v, 2, 6, 10, 14);
        g_mix(v, 3, 7, 11, 15);
        g_mix(v, 0, 5, 10, 15);
        g_mix(v, 1, 6, 11, 12);
        g_mix(v, 2, 7, 8, 13);
        g_mix(v, 3, 4, 9, 14);
        for (int i = 0; i < 16; i++) m[idx[i]] = v[i];
    endtask

    task automatic push_error(logic [1:0] code);
        pair_t p;
        p.even = '0;
        p.odd  = '0;
        p.last = 1'b1;
        p.stat = code;
        expected_q.push_back(p);
    endtask

    // work out the results of one accepted word
    task automatic predict_compress(req_item_t it);
        logic [63:0] m[NumWords];
        int          idx[16];
        pair_t       p;
        if (it.req == ReqLoad) begin
            if (fill >= FullCount) push_error(StatusOver);
            else begin
                if (fill < NumWords) r_block[fill] = it.word;
                else r_block[fill - NumWords] ^= it.word;
                fill++;
            end
        end else if (fill != FullCount) begin
            push_error(StatusEarly);
        end else begin
            m = r_block;
            for (int i = 0; i < 8; i++) begin
                for (int j = 0; j < 16; j++) idx[j] = 16 * i + j;
                permute(m, idx);
            end
            for (int i = 0; i < 8; i++) begin
                for (int j = 0; j < 8; j++) begin
                    idx[2 * j]     = 2 * i + 16 * j;
                    idx[2 * j + 1] = 2 * i + 16 * j + 1;
                end
                permute(m, idx);
            end
            for (int k = 0; k < 64; k++) begin
                p.even = m[2 * k] ^ r_block[2 * k];
                p.odd  = m[2 * k + 1] ^ r_block[2 * k + 1];
                p.last = (k == 63);
                p.stat = StatusOk;
                expected_q.push_back(p);
            end
            fill = 0;
        end
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch at pair %0d: %s got %h want %h", n_pairs_seen, what, got, want);
        n_errors++;
    endtask

    function automatic int pick_gap();
        if (!gaps_on) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    // driver: presents queued words, changes on the falling edge
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_acc)) begin
            if (send_gap > 0) begin
                send_gap--;
                in_valid <= 1'b0;
            end else if (pending_q.size() > 0) begin
                in_valid  <= 1'b1;
                req_type  <= pending_q[0].req;
                data_word <= pending_q[0].word;
                predict_compress(pending_q.pop_front());
                send_gap = pick_gap();
            end else begin
                in_valid <= 1'b0;
            end
        end
        if (rst_n) begin
            if (recv_gap > 0) begin
                recv_gap--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
                recv_gap = pick_gap();
            end
        end
    end

    // monitor: notes input acceptance, checks accepted result pairs at the rising edge
    always @(posedge clk)
    begin
        pair_t e;
        cycle_cnt++;
        in_acc = rst_n && in_valid && !in_stall;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected word_even", word_even, '0);
            end else begin
                e = expected_q.pop_front();
                if (word_even !== e.even) report_mismatch("word_even", word_even, e.even);
                if (word_odd !== e.odd) report_mismatch("word_odd", word_odd, e.odd);
                if (last_pair !== e.last)
                    report_mismatch("last_pair", 64'(last_pair), 64'(e.last));
                if (status !== e.stat)
                    report_mismatch("status", 64'(status), 64'(e.stat));
            end
            n_pairs_seen++;
        end
    end

    // timeout guard
    always @(posedge clk)
    begin
        if (cycle_cnt > 400000) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic add_word(logic req, logic [63:0] w);
        req_item_t it;
        it.req  = req;
        it.word = w;
        pending_q.push_back(it);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic wait_drained();
        while (pending_q.size() > 0 || expected_q.size() > 0 || in_valid) @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        req_type  = ReqLoad;
        data_word = '0;
        out_stall = 1'b0;
        n_errors  = 0;
        n_pairs_seen = 0;
        cycle_cnt = 0;
        send_gap  = 0;
        recv_gap  = 0;
        gaps_on   = 1'b1;
        in_acc    = 1'b0;
        fill      = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // early finalize on an empty block
        add_word(ReqFinalize, rand64());
        // a full block with early finalizes inside and some all-one words
        for (int i = 0; i < FullCount; i++) begin
            if (i == 100 || i == 200) add_word(ReqFinalize, {64{1'b1}});
            add_word(ReqLoad, (i % 17 == 0) ? {64{1'b1}} : rand64());
        end
        // overfill attempts, then the compression
        repeat (3) add_word(ReqLoad, rand64());
        add_word(ReqFinalize, '0);
        // a new run: early finalize, then a partial block
        add_word(ReqFinalize, '0);
        for (int i = 0; i < 64; i++) add_word(ReqLoad, rand64());
        add_word(ReqFinalize, rand64());
        wait_drained();

        if (n_errors == 0 && expected_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
